### sv/tssf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tssf_pkg - shared types and constants for the two-stage soft-clip fuzz
// Q8.24 clip thresholds, tanh constants, register map, sequencer states.
// ----------------------------------------------------------------------------
package tssf_pkg;

  localparam int CHANNELS_DEF = 2;
  localparam int CFG_IDX_W    = 3;
  localparam int DIV_STEPS    = 32;

  localparam logic signed [31:0] CLIP1_POS = 32'sd4194304;
  localparam logic signed [31:0] CLIP1_NEG = 32'sd3355443;
  localparam logic signed [31:0] CLIP2_POS = 32'sd6710886;
  localparam logic signed [31:0] CLIP2_NEG = 32'sd4697620;

  localparam logic [29:0] GAIN1_BASE  = 30'd83886080;  // 5.0
  localparam logic [29:0] GAIN1_SLOPE = 30'd25;
  localparam logic [29:0] GAIN2_BASE  = 30'd50331648;  // 3.0
  localparam logic [29:0] GAIN2_SLOPE = 30'd17;

  localparam logic [31:0] TANH_ONE   = 32'd16777216;
  // 7m+5 at or above 30.0 means 0.7*m has reached 3.0
  localparam logic [31:0] TANH_SAT   = 32'd503316480;
  // ceil(2^31/10), exact divide by ten for numerators below 2^30
  localparam logic [31:0] RECIP10    = 32'd214748365;
  localparam logic [30:0] TANH_K27   = 31'd452984832;  // 27.0

  localparam logic [15:0] FUZZ_RST     = 16'd0;
  localparam logic [15:0] LEVEL_RST    = 16'd0;
  localparam logic [15:0] COUPLING_RST = 16'd65208;
  localparam logic [15:0] LP1_RST      = 16'd15818;
  localparam logic [15:0] LP2_RST      = 16'd21919;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FUZZ     = 3'd0,
    REG_LEVEL    = 3'd1,
    REG_COUPLING = 3'd2,
    REG_LP1      = 3'd3,
    REG_LP2      = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] fuzz;
    logic [15:0] level;
    logic [15:0] coupling;
    logic [15:0] lp1;
    logic [15:0] lp2;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               channel;
  } res_t;

  typedef enum logic [4:0] {
    S_IDLE, S_IN_MUL, S_IN_ADD, S_G1_MUL, S_G1_ADD, S_C1_CHK, S_C1_DIV,
    S_LP1_MUL, S_LP1_ADD, S_G2_MUL, S_G2_ADD, S_C2_CHK, S_C2_DIV,
    S_LP2_MUL, S_LP2_ADD, S_VOL_MUL, S_VOL_ADD, S_OUT_MUL, S_OUT_ADD,
    S_TH_PREP, S_TH_SCALE, S_TH_SQ, S_TH_NUM, S_TH_MUL, S_TH_QDIV,
    S_TH_WAIT, S_TH_RND, S_DONE
  } state_t;

  function automatic logic signed [31:0] sat_q24(input logic signed [67:0] v);
    logic signed [31:0] r;
    if (v > 68'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -68'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### sv/two_stage_soft_clip_fuzz.sv
`default_nettype none
// ----------------------------------------------------------------------------
// two_stage_soft_clip_fuzz - two-stage soft-clip fuzz, per-channel state
// Config registers, output register and the shared-unit sequencer.
//
//   channel  signals                              payload
//   in       in_valid / in_ready                  in_sample, in_channel
//   out      out_valid / out_ready                out_sample, out_channel
//   cfg      cfg_valid / cfg_ready (always 1)     cfg_index, cfg_data
//
// Each soft clip that engages adds one divide on the shared divider, and
// tanh adds a square and then one divide when it is not saturated.
// One item at a time; in_ready is high only while the sequencer is idle.
// A finished item waits in the output register so the next can start.
// Reset (synchronous) clears filter state and loads default coefficients.
// ----------------------------------------------------------------------------
module two_stage_soft_clip_fuzz #(
  parameter int CHANNELS = tssf_pkg::CHANNELS_DEF
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                in_valid,
  output logic                               in_ready,
  input  wire signed [15:0]                  in_sample,
  input  wire                                in_channel,
  output logic                               out_valid,
  input  wire                                out_ready,
  output logic signed [15:0]                 out_sample,
  output logic                               out_channel,
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire  [tssf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [15:0]                        cfg_data
);

  tssf_pkg::cfg_t cfg;
  tssf_pkg::res_t res;
  logic           res_valid;
  logic           res_ready;

  assign cfg_ready = 1'b1;
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fuzz     <= tssf_pkg::FUZZ_RST;
      cfg.level    <= tssf_pkg::LEVEL_RST;
      cfg.coupling <= tssf_pkg::COUPLING_RST;
      cfg.lp1      <= tssf_pkg::LP1_RST;
      cfg.lp2      <= tssf_pkg::LP2_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        tssf_pkg::REG_FUZZ:     cfg.fuzz     <= cfg_data;
        tssf_pkg::REG_LEVEL:    cfg.level    <= cfg_data;
        tssf_pkg::REG_COUPLING: cfg.coupling <= cfg_data;
        tssf_pkg::REG_LP1:      cfg.lp1      <= cfg_data;
        tssf_pkg::REG_LP2:      cfg.lp2      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid   <= 1'b1;
      out_sample  <= res.sample;
      out_channel <= res.channel;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  tssf_seq #(.CHANNELS(CHANNELS)) u_seq (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .start_valid(in_valid),
    .start_ready(in_ready),
    .start_sample(in_sample),
    .start_channel(in_channel),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res(res)
  );

endmodule
`default_nettype wire

### sv/tssf_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tssf_mul - shared signed multiplier
// 34 x 32 bit signed product, registered.
// ----------------------------------------------------------------------------
module tssf_mul (
  input  wire                clk,
  input  wire signed [33:0]  a,
  input  wire signed [31:0]  b,
  output logic signed [65:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule
`default_nettype wire

### sv/tssf_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tssf_div - shared restoring divider
// Unsigned 64 / 35 bit, one quotient bit a cycle; quotient must fit 32 bits.
// ----------------------------------------------------------------------------
module tssf_div (
  input  wire         clk,
  input  wire         rst,
  input  wire         start,
  input  wire  [63:0] num,
  input  wire  [34:0] den,
  output logic        busy,
  output logic        done,
  output logic [31:0] quo
);

  localparam int CNT_W = $clog2(tssf_pkg::DIV_STEPS + 1);

  logic [34:0]      rem;
  logic [34:0]      dreg;
  logic [31:0]      nlow;
  logic [CNT_W-1:0] cnt;
  logic [35:0]      trial;
  logic             fits;

  assign trial = {rem, nlow[31]};
  assign fits  = trial >= {1'b0, dreg};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        // high word is below den when the quotient fits in 32 bits
        rem  <= 35'(num[63:32]);
        nlow <= num[31:0];
        dreg <= den;
        cnt  <= CNT_W'(tssf_pkg::DIV_STEPS);
        busy <= 1'b1;
      end else if (busy) begin
        rem  <= fits ? 35'(trial - {1'b0, dreg}) : trial[34:0];
        nlow <= {nlow[30:0], 1'b0};
        quo  <= {quo[30:0], fits};
        cnt  <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

### sv/tssf_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tssf_seq - sample sequencer and datapath
// Walks one sample through the chain on the shared multiplier and divider.
// ----------------------------------------------------------------------------
module tssf_seq #(
  parameter int CHANNELS = tssf_pkg::CHANNELS_DEF
) (
  input  wire                 clk,
  input  wire                 rst,
  input  tssf_pkg::cfg_t      cfg,
  input  wire                 start_valid,
  output logic                start_ready,
  input  wire signed [15:0]   start_sample,
  input  wire                 start_channel,
  output logic                res_valid,
  input  wire                 res_ready,
  output tssf_pkg::res_t      res
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  tssf_pkg::state_t state, state_next;

  logic signed [31:0] mem_in  [CHANNELS];
  logic signed [31:0] mem_lp1 [CHANNELS];
  logic signed [31:0] mem_lp2 [CHANNELS];
  logic signed [31:0] mem_out [CHANNELS];

  logic [CH_W-1:0]    ch;
  logic               chan;
  logic signed [31:0] cur;
  logic               neg;
  logic [31:0]        mag;
  logic [29:0]        tnum;
  logic [30:0]        tden;

  logic signed [33:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [65:0] p;
  logic               div_start;
  logic [63:0]        div_num;
  logic [34:0]        div_den;
  logic               div_busy;
  logic               div_done;
  logic [31:0]        quo;

  logic signed [67:0] dp_sum;
  logic signed [31:0] dp_sat;
  logic signed [67:0] rnd16, rnd17, rnd24;
  logic [29:0]        g1, g2;
  logic [18:0]        lvl7;

  logic               clip_two;
  logic signed [31:0] tpos, tneg;
  logic signed [33:0] over_hi, over_lo;
  logic               is_hi, is_lo;
  logic [30:0]        over;
  logic [63:0]        clip_num;
  logic [34:0]        clip_den;
  logic signed [33:0] abs34;
  logic [63:0]        tanh_num;
  logic               tanh_sat;
  logic [25:0]        ysum;
  logic [16:0]        yv;
  logic signed [17:0] yo;
  logic [27:0]        m2;

  tssf_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(p));

  tssf_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .busy(div_busy), .done(div_done), .quo(quo)
  );

  assign g1    = tssf_pkg::GAIN1_BASE + 30'({cfg.fuzz, 8'd0}) * tssf_pkg::GAIN1_SLOPE;
  assign g2    = tssf_pkg::GAIN2_BASE + 30'({cfg.fuzz, 8'd0}) * tssf_pkg::GAIN2_SLOPE;
  assign lvl7  = 19'(cfg.level) * 19'd7;
  assign rnd16 = (68'(p) + 68'sd32768) >>> 16;
  assign rnd17 = (68'(p) + 68'sd65536) >>> 17;
  assign rnd24 = (68'(p) + 68'sd8388608) >>> 24;
  assign dp_sat = tssf_pkg::sat_q24(dp_sum);

  // soft clip operands; stage 2 uses over/(1+1.5*over) as 2*over/(2+3*over)
  always_comb begin
    clip_two = (state == tssf_pkg::S_C2_CHK) || (state == tssf_pkg::S_C2_DIV);
    tpos     = clip_two ? tssf_pkg::CLIP2_POS : tssf_pkg::CLIP1_POS;
    tneg     = clip_two ? tssf_pkg::CLIP2_NEG : tssf_pkg::CLIP1_NEG;
    over_hi  = 34'(cur) - 34'(tpos);
    over_lo  = -34'(cur) - 34'(tneg);
    is_hi    = cur > tpos;
    is_lo    = 34'(cur) < -34'(tneg);
    over     = is_hi ? over_hi[30:0] : over_lo[30:0];
    clip_num = clip_two ? (64'(over) << 25) : (64'(over) << 24);
    clip_den = clip_two ? (35'd33554432 + 35'(over) * 35'd3) : (35'd16777216 + 35'(over));
    abs34    = cur[31] ? -34'(cur) : 34'(cur);
    tanh_num = 64'(abs34[31:0]) * 64'd7 + 64'd5;
    tanh_sat = tanh_num >= 64'(tssf_pkg::TANH_SAT);
    m2       = p[51:24];
    ysum     = 26'(mag[24:0]) + 26'd256;
    yv       = ysum[25:9];
    yo       = neg ? -$signed({1'b0, yv}) : $signed({1'b0, yv});
  end

  always_comb begin
    state_next = state;
    unique case (state)
      tssf_pkg::S_IDLE:     if (start_valid) state_next = tssf_pkg::S_IN_MUL;
      tssf_pkg::S_IN_MUL:   state_next = tssf_pkg::S_IN_ADD;
      tssf_pkg::S_IN_ADD:   state_next = tssf_pkg::S_G1_MUL;
      tssf_pkg::S_G1_MUL:   state_next = tssf_pkg::S_G1_ADD;
      tssf_pkg::S_G1_ADD:   state_next = tssf_pkg::S_C1_CHK;
      tssf_pkg::S_C1_CHK:   state_next = (is_hi || is_lo) ? tssf_pkg::S_C1_DIV
                                                          : tssf_pkg::S_LP1_MUL;
      tssf_pkg::S_C1_DIV:   if (div_done) state_next = tssf_pkg::S_LP1_MUL;
      tssf_pkg::S_LP1_MUL:  state_next = tssf_pkg::S_LP1_ADD;
      tssf_pkg::S_LP1_ADD:  state_next = tssf_pkg::S_G2_MUL;
      tssf_pkg::S_G2_MUL:   state_next = tssf_pkg::S_G2_ADD;
      tssf_pkg::S_G2_ADD:   state_next = tssf_pkg::S_C2_CHK;
      tssf_pkg::S_C2_CHK:   state_next = (is_hi || is_lo) ? tssf_pkg::S_C2_DIV
                                                          : tssf_pkg::S_LP2_MUL;
      tssf_pkg::S_C2_DIV:   if (div_done) state_next = tssf_pkg::S_LP2_MUL;
      tssf_pkg::S_LP2_MUL:  state_next = tssf_pkg::S_LP2_ADD;
      tssf_pkg::S_LP2_ADD:  state_next = tssf_pkg::S_VOL_MUL;
      tssf_pkg::S_VOL_MUL:  state_next = tssf_pkg::S_VOL_ADD;
      tssf_pkg::S_VOL_ADD:  state_next = tssf_pkg::S_OUT_MUL;
      tssf_pkg::S_OUT_MUL:  state_next = tssf_pkg::S_OUT_ADD;
      tssf_pkg::S_OUT_ADD:  state_next = tssf_pkg::S_TH_PREP;
      tssf_pkg::S_TH_PREP:  state_next = tanh_sat ? tssf_pkg::S_TH_RND
                                                  : tssf_pkg::S_TH_SCALE;
      tssf_pkg::S_TH_SCALE: state_next = tssf_pkg::S_TH_SQ;
      tssf_pkg::S_TH_SQ:    state_next = tssf_pkg::S_TH_NUM;
      tssf_pkg::S_TH_NUM:   state_next = tssf_pkg::S_TH_MUL;
      tssf_pkg::S_TH_MUL:   state_next = tssf_pkg::S_TH_QDIV;
      tssf_pkg::S_TH_QDIV:  state_next = tssf_pkg::S_TH_WAIT;
      tssf_pkg::S_TH_WAIT:  if (div_done) state_next = tssf_pkg::S_TH_RND;
      tssf_pkg::S_TH_RND:   state_next = tssf_pkg::S_DONE;
      tssf_pkg::S_DONE:     if (res_ready) state_next = tssf_pkg::S_IDLE;
      default:              state_next = tssf_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    mul_a       = 34'(cur);
    mul_b       = '0;
    div_start   = 1'b0;
    div_num     = clip_num;
    div_den     = clip_den;
    dp_sum      = '0;
    start_ready = (state == tssf_pkg::S_IDLE);
    res_valid   = (state == tssf_pkg::S_DONE);
    unique case (state)
      tssf_pkg::S_IN_MUL: begin
        mul_a = 34'(mem_in[ch]);
        mul_b = $signed({16'd0, cfg.coupling});
      end
      tssf_pkg::S_IN_ADD:  dp_sum = 68'(cur) - 68'(mem_in[ch]) + rnd16;
      tssf_pkg::S_G1_MUL:  mul_b = $signed({2'b00, g1});
      tssf_pkg::S_G2_MUL:  mul_b = $signed({2'b00, g2});
      tssf_pkg::S_G1_ADD,
      tssf_pkg::S_G2_ADD:  dp_sum = rnd24;
      tssf_pkg::S_C1_CHK,
      tssf_pkg::S_C2_CHK:  div_start = is_hi || is_lo;
      tssf_pkg::S_C1_DIV,
      tssf_pkg::S_C2_DIV: begin
        dp_sum = neg ? -(68'(tneg) + $signed({36'd0, quo}))
                     : 68'(tpos) + $signed({36'd0, quo});
      end
      tssf_pkg::S_LP1_MUL: begin
        mul_a = 34'(cur) - 34'(mem_lp1[ch]);
        mul_b = $signed({16'd0, cfg.lp1});
      end
      tssf_pkg::S_LP1_ADD: dp_sum = 68'(mem_lp1[ch]) + rnd16;
      tssf_pkg::S_LP2_MUL: begin
        mul_a = 34'(cur) - 34'(mem_lp2[ch]);
        mul_b = $signed({16'd0, cfg.lp2});
      end
      tssf_pkg::S_LP2_ADD: dp_sum = 68'(mem_lp2[ch]) + rnd16;
      tssf_pkg::S_VOL_MUL: mul_b = $signed({13'd0, lvl7});
      tssf_pkg::S_VOL_ADD: dp_sum = rnd17;
      tssf_pkg::S_OUT_MUL: begin
        mul_a = 34'(mem_out[ch]);
        mul_b = $signed({16'd0, cfg.coupling});
      end
      tssf_pkg::S_OUT_ADD: dp_sum = 68'(cur) - 68'(mem_out[ch]) + rnd16;
      tssf_pkg::S_TH_PREP: begin
        // 0.7*|x| rounded, as (7m+5)/10 by reciprocal multiply
        mul_a = $signed(tanh_num[33:0]);
        mul_b = $signed(tssf_pkg::RECIP10);
      end
      tssf_pkg::S_TH_SQ: begin
        mul_a = $signed({2'b00, mag});
        mul_b = $signed(mag);
      end
      tssf_pkg::S_TH_MUL: begin
        mul_a = $signed({2'b00, mag});
        mul_b = $signed({2'b00, tnum});
      end
      tssf_pkg::S_TH_QDIV: begin
        div_start = 1'b1;
        div_num   = 64'(p[55:0]);
        div_den   = 35'(tden);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tssf_pkg::S_IDLE;
      for (int i = 0; i < CHANNELS; i++) begin
        mem_in[i]  <= '0;
        mem_lp1[i] <= '0;
        mem_lp2[i] <= '0;
        mem_out[i] <= '0;
      end
    end else begin
      state <= state_next;
      unique case (state)
        tssf_pkg::S_IDLE: begin
          if (start_valid) begin
            cur  <= {{7{start_sample[15]}}, start_sample, 9'd0};
            ch   <= (CHANNELS > 1) ? CH_W'(start_channel) : '0;
            chan <= start_channel;
          end
        end
        tssf_pkg::S_IN_ADD: begin
          cur        <= dp_sat;
          mem_in[ch] <= dp_sat;
        end
        tssf_pkg::S_G1_ADD, tssf_pkg::S_G2_ADD, tssf_pkg::S_VOL_ADD: cur <= dp_sat;
        tssf_pkg::S_C1_CHK, tssf_pkg::S_C2_CHK: neg <= !is_hi;
        tssf_pkg::S_C1_DIV, tssf_pkg::S_C2_DIV: if (div_done) cur <= dp_sat;
        tssf_pkg::S_LP1_ADD: begin
          cur         <= dp_sat;
          mem_lp1[ch] <= dp_sat;
        end
        tssf_pkg::S_LP2_ADD: begin
          cur         <= dp_sat;
          mem_lp2[ch] <= dp_sat;
        end
        tssf_pkg::S_OUT_ADD: begin
          cur         <= dp_sat;
          mem_out[ch] <= dp_sat;
        end
        tssf_pkg::S_TH_PREP: begin
          neg <= cur[31];
          if (tanh_sat) mag <= tssf_pkg::TANH_ONE;
        end
        tssf_pkg::S_TH_SCALE: mag <= p[62:31];
        tssf_pkg::S_TH_NUM: begin
          tnum <= 30'(tssf_pkg::TANH_K27) + 30'(m2);
          tden <= tssf_pkg::TANH_K27 + 31'(m2) * 31'd9;
        end
        tssf_pkg::S_TH_WAIT: if (div_done) mag <= quo;
        tssf_pkg::S_TH_RND: begin
          res.sample  <= (yo > 18'sd32767) ? 16'sh7FFF : yo[15:0];
          res.channel <= chan;
        end
        default: begin
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_div_runs: assert property (@(posedge clk) disable iff (rst)
    div_start |=> div_busy) else $error("divider did not start");
  a_idle_div: assert property (@(posedge clk) disable iff (rst)
    (state == tssf_pkg::S_IDLE) |-> !div_busy) else $error("divider busy while idle");
  a_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == tssf_pkg::S_C1_DIV || state == tssf_pkg::S_C2_DIV ||
                  state == tssf_pkg::S_TH_WAIT))
    else $error("quotient arrived in wrong state");
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("result changed while waiting");
`endif

endmodule
`default_nettype wire

### tb/testbench.sv
// ----------------------------------------------------------------------------
// Two-stage soft-clip fuzz testbench
// Directed table then random samples on both channels, checked per item
// against an in-bench fixed-point model; random idling, config phases.
// ----------------------------------------------------------------------------
module testbench;

  localparam int NCH = 2;
  localparam longint Q1 = 64'sd16777216;
  localparam longint QMAX = 64'sd2147483647;
  localparam longint QMIN = -64'sd2147483648;
  localparam int CYCLE_LIMIT = 1500000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] in_sample = '0;
  logic in_channel = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] out_sample;
  logic out_channel;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [tssf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  two_stage_soft_clip_fuzz dut (.*);

  always #2 clk = ~clk;

  // shadow registers and per-channel filter memories
  logic [15:0] m_fuzz, m_level, m_coup, m_lp1, m_lp2;
  logic signed [31:0] st_in[NCH], st_lp1[NCH], st_lp2[NCH], st_out[NCH];

  typedef struct packed {
    logic signed [15:0] sample;
    logic               channel;
  } fuzz_out_t;
  fuzz_out_t expected_q[$];

  int errors = 0;
  int cycles = 0;
  int sender_idle = 0;   // percent
  int receiver_idle = 0;
  int hold_off = 0;      // cycles of forced receiver stall

  function automatic longint round_sh(longint v, int n);
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic logic signed [31:0] clamp_q24(longint v);
    if (v > QMAX) return 32'sh7FFFFFFF;
    if (v < QMIN) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] one_pole(logic signed [31:0] x,
                                                  inout logic signed [31:0] mem);
    longint z;
    z = mem;
    mem = clamp_q24(longint'(x) - z + round_sh(z * longint'(m_coup), 16));
    return mem;
  endfunction

  function automatic logic signed [31:0] smooth(logic signed [31:0] s,
                                                inout logic signed [31:0] mem,
                                                input logic [15:0] a);
    longint z;
    z = mem;
    mem = clamp_q24(z + round_sh((longint'(s) - z) * longint'(a), 16));
    return mem;
  endfunction

  function automatic logic signed [31:0] clip(logic signed [31:0] s, longint tp,
                                              longint tn, bit steep);
    longint v, ov, r;
    v = s;
    if (v > tp || v < -tn) begin
      ov = (v > tp) ? v - tp : -v - tn;
      r = steep ? (ov * 2 * Q1) / (2 * Q1 + 3 * ov) : (ov * Q1) / (Q1 + ov);
      return (v > tp) ? clamp_q24(tp + r) : clamp_q24(-(tn + r));
    end
    return s;
  endfunction

  function automatic logic signed [31:0] gain(logic signed [31:0] s, longint base,
                                              longint slope);
    longint g;
    g = base * Q1 + slope * longint'(m_fuzz) * 256;
    return clamp_q24(round_sh(longint'(s) * g, 24));
  endfunction

  function automatic longint tanh_q15(logic signed [31:0] x);
    longint unsigned m, y, m2;
    bit neg;
    neg = x < 0;
    m = neg ? -longint'(x) : longint'(x);
    m = (m * 7 + 5) / 10;
    if (m >= 3 * Q1) y = Q1;
    else begin
      m2 = (m * m) >> 24;
      y = (m * (27 * Q1 + m2)) / (27 * Q1 + 9 * m2);
    end
    y = (y + 256) >> 9;
    return neg ? -longint'(y) : longint'(y);
  endfunction

  function automatic fuzz_out_t process_sample(logic signed [15:0] smp, logic ch);
    logic signed [31:0] s;
    longint o;
    fuzz_out_t r;
    s = one_pole(32'(longint'(smp) * 512), st_in[ch]);
    s = gain(s, 5, 25);
    s = clip(s, tssf_pkg::CLIP1_POS, tssf_pkg::CLIP1_NEG, 1'b0);
    s = smooth(s, st_lp1[ch], m_lp1);
    s = gain(s, 3, 17);
    s = clip(s, tssf_pkg::CLIP2_POS, tssf_pkg::CLIP2_NEG, 1'b1);
    s = smooth(s, st_lp2[ch], m_lp2);
    s = clamp_q24(round_sh(longint'(s) * longint'(m_level) * 7, 17));
    s = one_pole(s, st_out[ch]);
    o = tanh_q15(s);
    if (o > 32767) o = 32767;
    if (o < -32768) o = -32768;
    r.sample = o[15:0];
    r.channel = ch;
    return r;
  endfunction

  task automatic write_reg(tssf_pkg::reg_idx_t idx, logic [15:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      tssf_pkg::REG_FUZZ:     m_fuzz = val;
      tssf_pkg::REG_LEVEL:    m_level = val;
      tssf_pkg::REG_COUPLING: m_coup = val;
      tssf_pkg::REG_LP1:      m_lp1 = val;
      tssf_pkg::REG_LP2:      m_lp2 = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);  // queue empty, so no item is in flight
  endtask

  task automatic send_sample(logic signed [15:0] smp, logic ch);
    while (sender_idle != 0 && $urandom_range(99) < sender_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_sample <= smp;
    in_channel <= ch;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_q.push_back(process_sample(smp, ch));
    @(negedge clk);
  endtask

  task automatic configure(logic [15:0] f, logic [15:0] l, logic [15:0] c,
                           logic [15:0] a1, logic [15:0] a2);
    write_reg(tssf_pkg::REG_FUZZ, f);
    write_reg(tssf_pkg::REG_LEVEL, l);
    write_reg(tssf_pkg::REG_COUPLING, c);
    write_reg(tssf_pkg::REG_LP1, a1);
    write_reg(tssf_pkg::REG_LP2, a2);
  endtask

  task automatic random_burst(int n);
    logic signed [15:0] smp;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: smp = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
        1: smp = $signed(16'($urandom_range(2047))) - 16'sd1024;
        default: smp = 16'($urandom);
      endcase
      send_sample(smp, 1'($urandom_range(1)));
    end
  endtask

  // receiver: random stall plus optional forced hold-off
  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !(receiver_idle != 0 && $urandom_range(99) < receiver_idle);
    end
  end

  // result checker
  always @(posedge clk) begin
    fuzz_out_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected item: %0d ch %0d", out_sample, out_channel);
      end else begin
        exp_r = expected_q.pop_front();
        if (exp_r.sample !== out_sample || exp_r.channel !== out_channel) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp %0d ch %0d got %0d ch %0d",
                     exp_r.sample, exp_r.channel, out_sample, out_channel);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // directed table: sample, channel
  localparam int NDIR = 14;
  logic signed [15:0] dir_smp[NDIR] = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'sh0001,
      16'shFFFF, 16'sh4000, 16'shC000, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000,
      16'sh5555, 16'shAAAA, 16'sh0100};
  logic dir_ch[NDIR] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1,
      1'b0, 1'b1, 1'b0, 1'b1};

  initial begin
    m_fuzz = tssf_pkg::FUZZ_RST; m_level = tssf_pkg::LEVEL_RST;
    m_coup = tssf_pkg::COUPLING_RST;
    m_lp1 = tssf_pkg::LP1_RST; m_lp2 = tssf_pkg::LP2_RST;
    for (int c = 0; c < NCH; c++) begin
      st_in[c] = 0; st_lp1[c] = 0; st_lp2[c] = 0; st_out[c] = 0;
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // after reset volume is zero, so every output is silent
    for (int i = 0; i < 4; i++) begin
      send_sample(dir_smp[i], dir_ch[i]);
      wait_drained();
    end
    configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    for (int i = 0; i < NDIR; i++) send_sample(dir_smp[i], dir_ch[i]);
    wait_drained();
    configure(16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
    for (int i = 0; i < 6; i++) send_sample(dir_smp[i], dir_ch[i]);
    wait_drained();
    write_reg(tssf_pkg::reg_idx_t'(3'd7), 16'h1234);  // unmapped index, no effect

    configure(16'h8000, 16'h8000, tssf_pkg::COUPLING_RST, tssf_pkg::LP1_RST,
              tssf_pkg::LP2_RST);
    sender_idle = 27; receiver_idle = 46;
    random_burst(250);

    // long receiver stall while the sender keeps pushing
    hold_off = 600;
    random_burst(20);
    wait_drained();

    configure(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom));
    sender_idle = 46; receiver_idle = 27;
    random_burst(250);
    wait_drained();

    configure(16'hFFFF, 16'h4000, 16'hFFFF, 16'h0100, 16'hFFFF);
    sender_idle = 0; receiver_idle = 0;
    random_burst(260);
    wait_drained();

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

### sim.f
sv/tssf_pkg.sv
sv/tssf_mul.sv
sv/tssf_div.sv
sv/tssf_seq.sv
sv/two_stage_soft_clip_fuzz.sv
tb/testbench.sv
